[rtl/bafp_pkg.sv]
package bafp_pkg;

   // Field widths fixed by the frame format
   localparam int BYTE_W      = 8;
   localparam int ANGLE_W     = 16;
   localparam int COUNT_W     = 3;
   localparam int TIMEOUT_W   = 16;
   localparam int AGE_W       = 17;
   localparam int NUM_ANGLES  = 6;

   localparam logic [AGE_W-1:0]     AGE_MAX        = 17'h1FFFF;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 16'd1000;

   // Command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Result kinds
   localparam logic KIND_OK        = 1'b0;
   localparam logic KIND_COUNT_ERR = 1'b1;

   // Characters of interest
   localparam logic [BYTE_W-1:0] CHAR_OPEN  = 8'h7B;
   localparam logic [BYTE_W-1:0] CHAR_CLOSE = 8'h7D;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   typedef struct packed {
      logic              command;
      logic [BYTE_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic [COUNT_W-1:0] value_count;
      logic [ANGLE_W-1:0] angle_a;
      logic [ANGLE_W-1:0] angle_b;
      logic [ANGLE_W-1:0] angle_c;
      logic [ANGLE_W-1:0] angle_d;
      logic [ANGLE_W-1:0] angle_e;
      logic [ANGLE_W-1:0] angle_f;
   } rsp_type;

   // What the parser core reports for the transaction it is offered
   typedef struct packed {
      logic    emit;
      rsp_type result;
   } step_type;

endpackage

[rtl/bafp_frame_core.sv]
module bafp_frame_core #(
   parameter int KEPT_CHAR_LIMIT  = 47,
   parameter int VALUES_PER_FRAME = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fire,
   input  bafp_pkg::req_type                   item,
   input  logic [bafp_pkg::TIMEOUT_W-1:0]      timeout,
   output bafp_pkg::step_type                  step
);
   import bafp_pkg::*;

   localparam int KC_W = $clog2(KEPT_CHAR_LIMIT + 1);
   localparam int VF_W = $clog2(VALUES_PER_FRAME + 1);
   localparam int IX_W = (VALUES_PER_FRAME > 1) ? $clog2(VALUES_PER_FRAME) : 1;

   logic                 in_frame_ff, in_frame_in;
   logic [KC_W-1:0]      kept_ff, kept_in;
   logic [AGE_W-1:0]     age_ff, age_in;
   logic [ANGLE_W-1:0]   accum_ff, accum_in;
   logic                 run_ff, run_in;
   logic [VF_W-1:0]      found_ff, found_in;
   logic [ANGLE_W-1:0]   store_ff [VALUES_PER_FRAME];

   logic                 is_digit;
   logic [ANGLE_W-1:0]   digit_val;
   logic [ANGLE_W-1:0]   accum_next;
   logic                 can_store;
   logic                 store_we;
   logic [AGE_W-1:0]     age_inc;
   logic [VF_W-1:0]      found_close;
   logic                 is_ok;
   logic                 is_close;
   logic [ANGLE_W-1:0]   angle [NUM_ANGLES];

   always_comb begin
      is_digit    = item.rx_byte inside {[CHAR_ZERO:CHAR_NINE]};
      digit_val   = ANGLE_W'(item.rx_byte - CHAR_ZERO);
      accum_next  = (accum_ff << 3) + (accum_ff << 1) + digit_val;
      can_store   = run_ff && (found_ff < VF_W'(VALUES_PER_FRAME));
      age_inc     = (age_ff == AGE_MAX) ? age_ff : age_ff + AGE_W'(1);
      found_close = found_ff + VF_W'(can_store);
      is_ok       = (found_close == VF_W'(VALUES_PER_FRAME));
      is_close    = (item.command == CMD_BYTE) && (item.rx_byte == CHAR_CLOSE);
   end

   // Next-state logic
   always_comb begin
      in_frame_in = in_frame_ff;
      kept_in     = kept_ff;
      age_in      = age_ff;
      accum_in    = accum_ff;
      run_in      = run_ff;
      found_in    = found_ff;
      store_we    = 1'b0;
      if (fire) begin
         if (item.command == CMD_TICK) begin
            if (in_frame_ff) begin
               age_in = age_inc;
               if (age_inc > {1'b0, timeout}) begin
                  in_frame_in = 1'b0;
                  kept_in     = '0;
                  age_in      = '0;
                  accum_in    = '0;
                  run_in      = 1'b0;
                  found_in    = '0;
               end
            end
         end else if (item.rx_byte == CHAR_OPEN || item.rx_byte == CHAR_CLOSE) begin
            // Open restarts a frame; close always leaves the parser idle
            in_frame_in = (item.rx_byte == CHAR_OPEN);
            kept_in     = '0;
            age_in      = '0;
            accum_in    = '0;
            run_in      = 1'b0;
            found_in    = '0;
         end else if (in_frame_ff && kept_ff < KC_W'(KEPT_CHAR_LIMIT)) begin
            kept_in = kept_ff + KC_W'(1);
            if (is_digit) begin
               accum_in = accum_next;
               run_in   = 1'b1;
            end else if (can_store) begin
               store_we = 1'b1;
               found_in = found_ff + VF_W'(1);
               accum_in = '0;
               run_in   = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         kept_ff     <= '0;
         age_ff      <= '0;
         accum_ff    <= '0;
         run_ff      <= 1'b0;
         found_ff    <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         kept_ff     <= kept_in;
         age_ff      <= age_in;
         accum_ff    <= accum_in;
         run_ff      <= run_in;
         found_ff    <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[found_ff[IX_W-1:0]] <= accum_ff;
      end
   end

   // A number still running at the close is taken straight from the accumulator
   for (genvar k = 0; k < NUM_ANGLES; k++) begin : g_angle
      if (k < VALUES_PER_FRAME) begin : g_used
         always_comb begin
            if (!is_ok) begin
               angle[k] = '0;
            end else if (can_store && found_ff == VF_W'(k)) begin
               angle[k] = accum_ff;
            end else begin
               angle[k] = store_ff[k];
            end
         end
      end else begin : g_unused
         assign angle[k] = '0;
      end
   end

   always_comb begin
      step.emit               = is_close && in_frame_ff && (kept_ff != '0);
      step.result.result_kind = is_ok ? KIND_OK : KIND_COUNT_ERR;
      step.result.value_count = COUNT_W'(found_close);
      step.result.angle_a     = angle[0];
      step.result.angle_b     = angle[1];
      step.result.angle_c     = angle[2];
      step.result.angle_d     = angle[3];
      step.result.angle_e     = angle[4];
      step.result.angle_f     = angle[5];
   end

endmodule

[rtl/brace_angle_frame_parser.sv]
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  bafp_pkg::req_type (command, rx_byte)
// rsp_      out        rsp_valid / rsp_stall  bafp_pkg::rsp_type (kind, count, six angles)
// csr_      in         csr_write              csr_wdata = frame timeout in ms
//
// One transaction per cycle sustained unless a waiting result stalls a closing brace;
// a closing-brace transaction's result passes the input register, then the result register.
// The parse step (multiply by ten and add, age compare) sits between the two.
// Reset is synchronous: parser idle, timeout back to 1000 ms, both registers empty.
// A pending result stalls only a closing-brace transaction; bytes and ticks
// that produce no result keep flowing while the result register waits.
module brace_angle_frame_parser #(
   parameter int KEPT_CHAR_LIMIT  = 47,
   parameter int VALUES_PER_FRAME = 6
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  bafp_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output bafp_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write,
   input  logic [bafp_pkg::TIMEOUT_W-1:0]    csr_wdata
);
   import bafp_pkg::*;

   // Input register: holds the transaction the core works on this cycle
   logic     in_vld_ff, in_vld_in;
   req_type  in_item_ff;

   // Result register: parts the core from the consumer
   logic     rsp_vld_ff, rsp_vld_in;
   rsp_type  rsp_data_ff;

   logic [TIMEOUT_W-1:0] timeout_ff;

   step_type step;
   logic     accept;
   logic     out_free;
   logic     advance;

   // Free when empty, or when the waiting result leaves this cycle
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   // Advance the held transaction unless it needs the result register and that is busy
   assign advance   = in_vld_ff && (!step.emit || out_free);
   assign req_stall = in_vld_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (advance && step.emit) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_vld_ff && !rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_write) begin
            timeout_ff <= csr_wdata;
         end
      end
   end

   // Payload registers: load on accept / on emit, hold otherwise
   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= req_data;
      end
      if (advance && step.emit) begin
         rsp_data_ff <= step.result;
      end
   end

   bafp_frame_core #(
      .KEPT_CHAR_LIMIT  (KEPT_CHAR_LIMIT),
      .VALUES_PER_FRAME (VALUES_PER_FRAME)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (advance),
      .item    (in_item_ff),
      .timeout (timeout_ff),
      .step    (step)
   );

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // A full frame always reports the configured number of values
   a_ok_count : assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_data_ff.result_kind == KIND_OK
      |-> rsp_data_ff.value_count == COUNT_W'(VALUES_PER_FRAME))
      else $error("ok result with wrong value count");

   // An error result carries no angles
   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_data_ff.result_kind == KIND_COUNT_ERR
      |-> rsp_data_ff.angle_a == '0 && rsp_data_ff.angle_f == '0)
      else $error("error result with nonzero angle");

   // An emitting transaction that advances shows up as a result next cycle
   a_emit_lands : assert property (@(posedge clock) disable iff (reset)
      advance && step.emit |=> rsp_vld_ff)
      else $error("emitted result lost");

   // The input side never stalls with an empty input register
   a_stall_held : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_vld_ff && step.emit && rsp_vld_ff && rsp_stall)
      else $error("input stalled without cause");
`endif

endmodule
